FILE: hdl/pds_pkg.sv
// Shared types, constants and constant tables of the posterior decoding segmenter.
package pds_pkg;

    localparam int NUM_CLASSES = 8;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [3:0]  NONE_CLASS  = 4'd8;
    localparam logic [33:0] LOG_SUM_MAX = 34'h1_FFFF_FFFF;

    typedef struct packed {
        logic [15:0] start;
        logic [16:0] width;
        logic [3:0]  cls;
        logic [33:0] sum;
        logic        last;
    } seg_rec_t;

    typedef logic [11:0][30:0] exp_tab_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] bitv;
        x    = x_in;
        res  = 64'd0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 64'd0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Entry j holds 2^(2^(j-12)) in Q1.30, each a square root of the one above.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    t;
        logic [63:0] v;
        v     = isqrt64(64'd2 << 60);
        t[11] = v[30:0];
        for (int j = 11; j > 0; j--) begin
            v         = isqrt64({2'd0, t[j], 31'd0} >> 1);
            t[j - 1]  = v[30:0];
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

FILE: hdl/pds_front.sv
// Front end: argmax over the class probabilities, fixed-point log2 and segment tracking.
module pds_front
    import pds_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [3:0]       num_classes,
    input  logic             push,
    output logic             full,
    input  logic [15:0]      position,
    input  logic [7:0][15:0] probs,
    input  logic             last_position,
    output seg_rec_t         rec,
    output logic             rec_push,
    input  logic             fifo_full
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOG  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;
    localparam logic [1:0] ST_EMB  = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [15:0] pos_reg;
    logic        last_reg;
    logic [3:0]  cls_reg;
    logic [3:0]  k_reg;
    logic [15:0] m_reg;
    logic [11:0] frac_reg;
    logic [3:0]  cnt_reg;
    logic        open_reg, open_next;
    logic [3:0]  cur_reg, cur_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] prev_reg, prev_next;
    logic [33:0] sum_reg, sum_next;

    logic [3:0]  n_use;
    logic [15:0] best;
    logic [3:0]  best_cls;
    logic [3:0]  lead;
    logic [31:0] sq;
    logic [16:0] sq_s;
    logic [16:0] mag;
    logic [34:0] sum_add;
    logic        need_a;
    logic        accept;

    assign accept = push && !full;
    assign full   = (state_reg != ST_IDLE);

    always_comb
    begin
        n_use    = (num_classes > 4'(NUM_CLASSES)) ? 4'(NUM_CLASSES) : num_classes;
        best     = 16'd0;
        best_cls = NONE_CLASS;
        for (int i = 0; i < NUM_CLASSES; i++) begin
            if ((4'(i) < n_use) && (probs[i] > best)) begin
                best     = probs[i];
                best_cls = 4'(i);
            end
        end
        lead = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (best[i]) lead = 4'(i);
        end
    end

    assign sq      = m_reg * m_reg;
    assign sq_s    = sq[31:15];
    assign mag     = (cls_reg == NONE_CLASS) ? 17'd0 :
                     ({5'd16 - {1'b0, k_reg}, 12'd0} - {5'd0, frac_reg});
    assign sum_add = {1'b0, sum_reg} + {18'd0, mag};
    assign need_a  = open_reg && (cls_reg != cur_reg);

    always_comb
    begin
        state_next = state_reg;
        open_next  = open_reg;
        cur_next   = cur_reg;
        start_next = start_reg;
        prev_next  = prev_reg;
        sum_next   = sum_reg;
        rec_push   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    state_next = (best_cls == NONE_CLASS) ? ST_FIN : ST_LOG;
                end
            end
            ST_LOG:
            begin
                if (cnt_reg == 4'd11) state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!need_a || !fifo_full) begin
                    rec_push = need_a;
                    if (open_reg && !need_a) begin
                        sum_next = (sum_add > {1'b0, LOG_SUM_MAX}) ? LOG_SUM_MAX
                                                                    : sum_add[33:0];
                    end else begin
                        open_next  = 1'b1;
                        cur_next   = cls_reg;
                        start_next = pos_reg;
                        sum_next   = {17'd0, mag};
                    end
                    prev_next  = pos_reg;
                    state_next = last_reg ? ST_EMB : ST_IDLE;
                end
            end
            ST_EMB:
            begin
                if (!fifo_full) begin
                    rec_push   = 1'b1;
                    open_next  = 1'b0;
                    sum_next   = 34'd0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Both records describe the segment held in the tracking registers.
    assign rec.start = start_reg;
    assign rec.width = {1'b0, prev_reg - start_reg} + 17'd1;
    assign rec.cls   = cur_reg;
    assign rec.sum   = sum_reg;
    assign rec.last  = (state_reg == ST_EMB) ? 1'b1 : !last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            open_reg  <= 1'b0;
            cur_reg   <= 4'd0;
            start_reg <= 16'd0;
            prev_reg  <= 16'd0;
            sum_reg   <= 34'd0;
        end else begin
            state_reg <= state_next;
            open_reg  <= open_next;
            cur_reg   <= cur_next;
            start_reg <= start_next;
            prev_reg  <= prev_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && accept) begin
            pos_reg  <= position;
            last_reg <= last_position;
            cls_reg  <= best_cls;
            k_reg    <= lead;
            m_reg    <= best << (4'd15 - lead);
            frac_reg <= 12'd0;
            cnt_reg  <= 4'd0;
        end else if (state_reg == ST_LOG) begin
            m_reg    <= sq_s[16] ? sq_s[16:1] : sq_s[15:0];
            frac_reg <= {frac_reg[10:0], sq_s[16]};
            cnt_reg  <= cnt_reg + 4'd1;
        end
    end

`ifndef SYNTHESIS
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        rec_push |-> !fifo_full)
        else $error("segment record pushed into a full queue");
    a_log_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOG && cnt_reg == 4'd11) |=> state_reg == ST_FIN)
        else $error("log iteration did not end after twelve steps");
`endif

endmodule

FILE: hdl/pds_fifo.sv
// Short record queue between the front end and the scoring back end.
module pds_fifo
    import pds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  seg_rec_t wr_data,
    output logic     full_q,
    input  logic     rd_en,
    output seg_rec_t rd_data,
    output logic     empty_q
);

    localparam int PW = $clog2(FIFO_DEPTH);

    seg_rec_t        mem [FIFO_DEPTH];
    logic [PW-1:0]   wp_reg;
    logic [PW-1:0]   rp_reg;
    logic [PW:0]     cnt_reg;
    logic            do_wr;
    logic            do_rd;

    assign full_q  = (cnt_reg == (PW+1)'(FIFO_DEPTH));
    assign empty_q = (cnt_reg == '0);
    assign do_wr   = wr_en && !full_q;
    assign do_rd   = rd_en && !empty_q;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr) mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) wp_reg <= wp_reg + PW'(1);
            if (do_rd) rp_reg <= rp_reg + PW'(1);
            cnt_reg <= cnt_reg + (PW+1)'(do_wr) - (PW+1)'(do_rd);
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(FIFO_DEPTH))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        wp_reg == PW'(rp_reg + cnt_reg[PW-1:0]))
        else $error("queue pointers disagree with count");
`endif

endmodule

FILE: hdl/pds_back.sv
// Back end: mean log by long division, exp2 by a table product, and the result register.
module pds_back
    import pds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seg_rec_t    rec,
    input  logic        rec_empty,
    output logic        rec_pop,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] seg_start,
    output logic [16:0] seg_width,
    output logic [2:0]  class_index,
    output logic        is_none,
    output logic [15:0] score,
    output logic        final_segment
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CHK  = 3'd2;
    localparam logic [2:0] ST_EXP  = 3'd3;
    localparam logic [2:0] ST_SHF  = 3'd4;
    localparam logic [2:0] ST_HOLD = 3'd5;

    logic [2:0]  state_reg;
    seg_rec_t    rec_reg;
    logic [33:0] dvd_reg;
    logic [16:0] rem_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] e_reg;
    logic [11:0] r_reg;
    logic [5:0]  q_reg;
    logic [3:0]  j_reg;
    logic [15:0] sc_reg;
    logic        out_valid_reg;

    logic [17:0] rs;
    logic        ge;
    logic [34:0] q_sum;
    logic [33:0] neg_inv;
    logic [62:0] prod;
    logic [31:0] shifted;
    logic        out_load;
    logic        rec_none;

    assign rec_none = (rec.cls == NONE_CLASS);
    assign rec_pop  = (state_reg == ST_IDLE) && !rec_empty;
    assign out_load = (state_reg == ST_HOLD) && (!out_valid_reg || pop);

    assign rs      = {rem_reg, dvd_reg[33]};
    assign ge      = rs >= {1'b0, rec_reg.width};
    assign q_sum   = {1'b0, dvd_reg} + 35'd4095;
    assign neg_inv = ~dvd_reg + 34'd1;
    assign prod    = e_reg * EXP_TAB[j_reg];
    assign shifted = e_reg >> (6'd14 + q_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!rec_empty) state_reg <= rec_none ? ST_HOLD : ST_DIV;
                end
                ST_DIV:
                begin
                    if (cnt_reg == 6'd33) state_reg <= ST_CHK;
                end
                ST_CHK:
                begin
                    if (dvd_reg == 34'd0 || q_sum[34:12] >= 23'd49) state_reg <= ST_HOLD;
                    else state_reg <= ST_EXP;
                end
                ST_EXP:
                begin
                    if (j_reg == 4'd0) state_reg <= ST_SHF;
                end
                ST_SHF:
                begin
                    state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (out_load) state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
            if (out_load) out_valid_reg <= 1'b1;
            else if (pop) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                rec_reg <= rec;
                dvd_reg <= rec.sum;
                rem_reg <= 17'd0;
                cnt_reg <= 6'd0;
                sc_reg  <= 16'd0;
            end
            ST_DIV:
            begin
                rem_reg <= ge ? 17'(rs - {1'b0, rec_reg.width}) : rs[16:0];
                dvd_reg <= {dvd_reg[32:0], ge};
                cnt_reg <= cnt_reg + 6'd1;
            end
            ST_CHK:
            begin
                // A zero mean log saturates; a deep negative one underflows to zero.
                sc_reg <= (dvd_reg == 34'd0) ? 16'hFFFF : 16'd0;
                q_reg  <= q_sum[17:12];
                r_reg  <= neg_inv[11:0];
                e_reg  <= 32'd1 << 30;
                j_reg  <= 4'd11;
            end
            ST_EXP:
            begin
                if (r_reg[j_reg]) e_reg <= prod[61:30];
                j_reg <= j_reg - 4'd1;
            end
            ST_SHF:
            begin
                sc_reg <= (shifted > 32'd65535) ? 16'hFFFF : shifted[15:0];
            end
            default:
            begin
            end
        endcase
        if (out_load) begin
            seg_start     <= rec_reg.start;
            seg_width     <= rec_reg.width;
            is_none       <= (rec_reg.cls == NONE_CLASS);
            class_index   <= (rec_reg.cls == NONE_CLASS) ? 3'd0 : rec_reg.cls[2:0];
            score         <= sc_reg;
            final_segment <= rec_reg.last;
        end
    end

    assign empty = !out_valid_reg;

`ifndef SYNTHESIS
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rec_reg.width != 17'd0)
        else $error("division by a zero segment width");
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> out_valid_reg)
        else $error("waiting result lost");
`endif

endmodule

FILE: hdl/posterior_decoding_segmenter.sv
// Top level of the posterior decoding segmenter.
// Input channel: one position per beat (position, prob_0..prob_7, last_position),
// taken at a rising edge with push high and full low. The front end runs a
// 12-step squaring loop for the log2 of the winning probability (an all-zero
// position skips it) and takes no new position until done; last_position adds
// a step for the end record; it waits while the four-entry record queue is full.
// Result channel: while empty is low the oldest segment is on seg_start,
// seg_width, class_index, is_none, score and final_segment; pop takes it.
// Each closed segment is scored by a bit-serial long division and a 12-step
// table product on its way from the queue to the result register; the product
// is skipped when the score saturates or underflows, a 'none' segment skips both.
// An item causes zero, one or two results, the last one with final_segment set.
// When the receiver stalls, the result register holds, the back end waits,
// the queue fills, and then full rises and the input side stops.
// Reset clears the segment state and the queue, empties the result register and sets
// num_classes to 8. cfg_we writes num_classes from cfg_wdata; write it only
// while the block is idle.
module posterior_decoding_segmenter
    import pds_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [3:0]  cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [15:0] position,
    input  logic [15:0] prob_0,
    input  logic [15:0] prob_1,
    input  logic [15:0] prob_2,
    input  logic [15:0] prob_3,
    input  logic [15:0] prob_4,
    input  logic [15:0] prob_5,
    input  logic [15:0] prob_6,
    input  logic [15:0] prob_7,
    input  logic        last_position,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] seg_start,
    output logic [16:0] seg_width,
    output logic [2:0]  class_index,
    output logic        is_none,
    output logic [15:0] score,
    output logic        final_segment
);

    logic [3:0]       num_classes_reg;
    logic [7:0][15:0] probs;
    seg_rec_t         wr_rec;
    seg_rec_t         rd_rec;
    logic             rec_push;
    logic             rec_pop;
    logic             q_full;
    logic             q_empty;

    assign probs = {prob_7, prob_6, prob_5, prob_4, prob_3, prob_2, prob_1, prob_0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) num_classes_reg <= 4'd8;
        else if (cfg_we) num_classes_reg <= cfg_wdata;
    end

    pds_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .num_classes   (num_classes_reg),
        .push          (push),
        .full          (full),
        .position      (position),
        .probs         (probs),
        .last_position (last_position),
        .rec           (wr_rec),
        .rec_push      (rec_push),
        .fifo_full     (q_full)
    );

    pds_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_push),
        .wr_data (wr_rec),
        .full_q  (q_full),
        .rd_en   (rec_pop),
        .rd_data (rd_rec),
        .empty_q (q_empty)
    );

    pds_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .rec           (rd_rec),
        .rec_empty     (q_empty),
        .rec_pop       (rec_pop),
        .empty         (empty),
        .pop           (pop),
        .seg_start     (seg_start),
        .seg_width     (seg_width),
        .class_index   (class_index),
        .is_none       (is_none),
        .score         (score),
        .final_segment (final_segment)
    );

endmodule

FILE: test/tb.sv
// Testbench of the posterior decoding segmenter: table-driven and random positions, predicted segments.
module tb;
    import pds_pkg::*;

    typedef struct {
        logic [15:0] start;
        logic [16:0] width;
        logic [2:0]  cls;
        logic        none;
        logic [15:0] score;
        logic        fin;
    } segment_t;

    typedef struct {
        logic [15:0]      pos;
        logic [7:0][15:0] prob;
        logic             last;
        logic             has_exp;
        segment_t         exp_seg;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [3:0] cfg_wdata = 4'd0;
    logic push = 1'b0;
    logic full;
    logic [15:0] position = 16'd0;
    logic [7:0][15:0] prob = '0;
    logic last_position = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic [15:0] seg_start;
    logic [16:0] seg_width;
    logic [2:0] class_index;
    logic is_none;
    logic [15:0] score;
    logic final_segment;

    // Predictor state.
    logic [3:0]  p_ncls;
    logic        p_open;
    logic [3:0]  p_class;
    logic [15:0] p_start;
    logic [15:0] p_prev;
    logic [33:0] p_sum;

    segment_t seg_q[$];
    bit       typed_q[$];
    segment_t typed_seg_q[$];
    int errors = 0;
    int idle_pct = 31;
    int quiet = 0;

    always #1 clk = ~clk;

    posterior_decoding_segmenter u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .push(push), .full(full), .position(position),
        .prob_0(prob[0]), .prob_1(prob[1]), .prob_2(prob[2]), .prob_3(prob[3]),
        .prob_4(prob[4]), .prob_5(prob[5]), .prob_6(prob[6]), .prob_7(prob[7]),
        .last_position(last_position), .empty(empty), .pop(pop),
        .seg_start(seg_start), .seg_width(seg_width), .class_index(class_index),
        .is_none(is_none), .score(score), .final_segment(final_segment)
    );

    function automatic logic [63:0] root64(input logic [63:0] xi);
        logic [63:0] x, r, b;
        x = xi;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] log_magnitude(input logic [15:0] p);
        int k;
        logic [63:0] m, frac;
        k = 15;
        frac = 0;
        while (k > 0 && p[k] == 1'b0) k--;
        m = 64'(p) << (15 - k);
        for (int i = 0; i < 12; i++) begin
            m = (m * m) >> 15;
            frac = frac << 1;
            if (m >= 65536) begin
                frac = frac | 1;
                m = m >> 1;
            end
        end
        return 64'(16 - k) * 4096 - frac;
    endfunction

    function automatic logic [15:0] mean_score(input logic [63:0] sum, input logic [63:0] w);
        logic [63:0] tab[12];
        logic [63:0] neg, q, r, e, sh;
        neg = sum / w;
        if (neg == 0) return 16'hFFFF;
        q = (neg + 4095) >> 12;
        r = q * 4096 - neg;
        tab[11] = root64(64'd2 << 60);
        for (int j = 11; j > 0; j--) tab[j - 1] = root64(tab[j] << 30);
        e = 64'd1 << 30;
        for (int j = 11; j >= 0; j--)
            if (r[j]) e = (e * tab[j]) >> 30;
        sh = 14 + q;
        if (sh >= 63) return 16'd0;
        e = e >> sh;
        return e > 65535 ? 16'hFFFF : e[15:0];
    endfunction

    function automatic segment_t close_segment();
        segment_t s;
        logic [16:0] w;
        w = {1'b0, p_prev - p_start} + 17'd1;
        s.start = p_start;
        s.width = w;
        s.none = (p_class >= NONE_CLASS);
        s.cls = s.none ? 3'd0 : p_class[2:0];
        s.score = s.none ? 16'd0 : mean_score(64'(p_sum), 64'(w));
        s.fin = 1'b0;
        return s;
    endfunction

    // Advances the predictor by one position and queues the segments it closes.
    task automatic predict_position(input row_t rw);
        int n, cnt;
        logic [15:0] best;
        logic [3:0] c;
        logic [63:0] mag, acc;
        segment_t s[2];
        n = p_ncls > NUM_CLASSES ? NUM_CLASSES : p_ncls;
        best = 0;
        c = NONE_CLASS;
        mag = 0;
        cnt = 0;
        for (int i = 0; i < n; i++)
            if (rw.prob[i] > best) begin
                best = rw.prob[i];
                c = i[3:0];
            end
        if (c != NONE_CLASS) mag = log_magnitude(best);
        if (p_open && c == p_class) begin
            acc = 64'(p_sum) + mag;
            p_sum = acc > 64'(LOG_SUM_MAX) ? LOG_SUM_MAX : acc[33:0];
        end else begin
            if (p_open) begin
                s[cnt] = close_segment();
                cnt++;
            end
            p_open = 1'b1;
            p_class = c;
            p_start = rw.pos;
            p_sum = mag[33:0];
        end
        p_prev = rw.pos;
        if (rw.last) begin
            s[cnt] = close_segment();
            cnt++;
            p_open = 1'b0;
            p_sum = 0;
        end
        if (cnt > 0) s[cnt - 1].fin = 1'b1;
        for (int i = 0; i < cnt; i++) begin
            seg_q = {seg_q, s[i]};
            typed_q = {typed_q, bit'(rw.has_exp && i == cnt - 1)};
            typed_seg_q = {typed_seg_q, rw.exp_seg};
        end
    endtask

    // Push stays high from one beat to the next unless the sender idles.
    task automatic send_position(input row_t rw);
        while ($urandom_range(99) < idle_pct) begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        position <= rw.pos;
        prob <= rw.prob;
        last_position <= rw.last;
        @(posedge clk);
        while (full) @(posedge clk);
        predict_position(rw);
        @(negedge clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (seg_q.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_classes(input logic [3:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        p_ncls = v;
    endtask

    function automatic row_t make_row(input logic [15:0] pos, input logic [15:0] p0,
                                      input logic [15:0] p1, input logic lst);
        row_t rw;
        rw.pos = pos;
        rw.prob = '0;
        rw.prob[0] = p0;
        rw.prob[1] = p1;
        rw.last = lst;
        rw.has_exp = 1'b0;
        rw.exp_seg = '{default: '0};
        return rw;
    endfunction

    // Result side: random stalls and the check against the oldest prediction.
    always @(negedge clk) pop <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk) begin
        if (rst_n && pop && !empty) begin
            segment_t e;
            segment_t t;
            quiet = 0;
            if (seg_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected segment start=%0d", seg_start);
            end else begin
                e = seg_q.pop_front();
                t = typed_seg_q.pop_front();
                if (typed_q.pop_front()) e = t;
                if (seg_start !== e.start || seg_width !== e.width
                    || class_index !== e.cls || is_none !== e.none
                    || score !== e.score || final_segment !== e.fin) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch exp %0d/%0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d/%0d",
                            e.start, e.width, e.cls, e.none, e.score, e.fin,
                            seg_start, seg_width, class_index, is_none, score,
                            final_segment);
                end
            end
        end else if (rst_n && push && !full) begin
            quiet = 0;
        end else if (rst_n) begin
            quiet++;
        end
        if (quiet >= 20000) begin
            $display("posterior_decoding_segmenter test failed");
            $finish;
        end
    end

    initial begin
        row_t tab[$];
        row_t rw;
        int mode;
        logic [15:0] pos;
        p_ncls = 4'd8;
        p_open = 0;
        p_class = 0;
        p_start = 0;
        p_prev = 0;
        p_sum = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Full-scale probability on one position: log2 is one step below zero.
        rw = make_row(16'd0, 16'hFFFF, 16'd0, 1'b1);
        rw.has_exp = 1;
        rw.exp_seg = '{16'd0, 17'd1, 3'd0, 1'b0, mean_score(64'd1, 64'd1), 1'b1};
        tab = {tab, rw};
        // All-zero position is a 'none' segment with score zero.
        rw = make_row(16'hFFFF, 16'd0, 16'd0, 1'b1);
        rw.has_exp = 1;
        rw.exp_seg = '{16'hFFFF, 17'd1, 3'd0, 1'b1, 16'd0, 1'b1};
        tab = {tab, rw};
        tab = {tab, make_row(16'd10, 16'd1, 16'd1, 1'b0)};     // tie goes to class 0
        tab = {tab, make_row(16'd11, 16'd1, 16'd1, 1'b0)};
        tab = {tab, make_row(16'd12, 16'd5, 16'd900, 1'b1)};   // change plus last
        tab = {tab, make_row(16'd5, 16'd7, 16'd0, 1'b1)};      // repeated last
        tab = {tab, make_row(16'd6, 16'd7, 16'd0, 1'b1)};
        tab = {tab, make_row(16'hFFF0, 16'd3, 16'd0, 1'b0)};   // coordinates wrap
        tab = {tab, make_row(16'd4, 16'd3, 16'd0, 1'b1)};
        tab = {tab, make_row(16'd100, 16'd1, 16'd0, 1'b0)};
        tab = {tab, make_row(16'd50, 16'd1, 16'd0, 1'b1)};     // backwards
        rw = make_row(16'd20, 16'd0, 16'd0, 1'b0);
        rw.prob[7] = 16'hFFFF;
        tab = {tab, rw};
        rw.pos = 16'd21;
        rw.prob[6] = 16'hFFFF;
        rw.last = 1;
        tab = {tab, rw};
        foreach (tab[i]) send_position(tab[i]);

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_classes(4'd1);
                1: write_classes(4'd0);
                2: write_classes(4'd15);
                3: write_classes(4'd3);
                4: write_classes(4'd8);
                default: write_classes(4'd5);
            endcase
            idle_pct = (ph == 4) ? 0 : 31;
            pos = 16'($urandom);
            for (int i = 0; i < 100; i++) begin
                mode = $urandom_range(9);
                rw.pos = (mode == 0) ? 16'($urandom) : pos;
                pos = rw.pos + 16'd1;
                for (int c = 0; c < 8; c++)
                    case ($urandom_range(5))
                        0: rw.prob[c] = 16'd0;
                        1: rw.prob[c] = 16'hFFFF;
                        2: rw.prob[c] = 16'($urandom_range(15));
                        default: rw.prob[c] = 16'($urandom);
                    endcase
                // Long same-class runs: push class 0 near full scale on half of the positions.
                if (mode < 5) rw.prob[0] = 16'hFFFF - 16'($urandom_range(3));
                if (mode == 9) rw.prob = '0;
                rw.last = ($urandom_range(15) == 0);
                rw.has_exp = 0;
                send_position(rw);
            end
            if (ph == 2) drain();
        end

        drain();
        if (errors == 0 && seg_q.size() == 0)
            $display("posterior_decoding_segmenter test passed");
        else
            $display("posterior_decoding_segmenter test failed");
        $finish;
    end
endmodule

FILE: sim.f
hdl/pds_pkg.sv
hdl/pds_front.sv
hdl/pds_fifo.sv
hdl/pds_back.sv
hdl/posterior_decoding_segmenter.sv
test/tb.sv
